// ===== design/dnsd_pkg.sv =====
// ----------------------------------------------------------------------------
// dnsd_pkg
// Shared constants and types of the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnsd_pkg;

   localparam int MSG_BYTES_DEF = 1024;
   localparam int NAME_MAX_DEF  = 256;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic REG_NAME_CAPACITY = 1'b0;
   localparam logic [8:0] CAP_RESET   = 9'd256;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BOUNDS   = 3'd1;
   localparam logic [2:0] ST_LOOP     = 3'd2;
   localparam logic [2:0] ST_RESERVED = 3'd3;
   localparam logic [2:0] ST_LONG     = 3'd4;

   localparam logic [4:0] MAX_HOPS  = 5'd16;
   localparam logic [1:0] TAG_LABEL = 2'b00;
   localparam logic [1:0] TAG_PTR   = 2'b11;
   localparam logic [7:0] DOT_CHAR  = 8'h2e;
   localparam logic [3:0] CHUNK_MAX = 4'd8;

   typedef struct packed {
      logic [63:0] name_chunk;
      logic [3:0]  chunk_bytes;
      logic        last;
      logic [2:0]  status;
      logic [10:0] consumed;
   } dnsd_rsp_type;

endpackage

// ===== design/dnsd_msg_ram.sv =====
// ----------------------------------------------------------------------------
// dnsd_msg_ram
// Message byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
module dnsd_msg_ram #(
   parameter int DEPTH = dnsd_pkg::MSG_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [7:0]               rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dnsd_addcmp.sv =====
// ----------------------------------------------------------------------------
// dnsd_addcmp
// Shared adder and bound comparator used by the name walker for every
// bounds and pointer target check and for the label capacity check.
// ----------------------------------------------------------------------------
module dnsd_addcmp #(
   parameter int WIDTH = 14
) (
   input  logic [WIDTH-1:0] opa,
   input  logic [WIDTH-1:0] opb,
   input  logic [WIDTH-1:0] bound,
   output logic             over
);

   logic [WIDTH:0] sum;

   assign sum  = {1'b0, opa} + {1'b0, opb};
   assign over = sum > {1'b0, bound};

endmodule

// ===== design/dnsd_walker.sv =====
// ----------------------------------------------------------------------------
// dnsd_walker
// Sequencer that walks labels and compression pointers in the message
// store, packs the name into chunks and drives the response register.
// ----------------------------------------------------------------------------
module dnsd_walker #(
   parameter int MSG_BYTES = dnsd_pkg::MSG_BYTES_DEF,
   parameter int NAME_MAX  = dnsd_pkg::NAME_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [9:0]                       start_offset,
   input  logic [$clog2(MSG_BYTES+1)-1:0]   msg_len,
   input  logic [8:0]                       cap,
   output logic [$clog2(MSG_BYTES)-1:0]     rd_addr,
   input  logic [7:0]                       rd_data,
   output logic                             busy,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output dnsd_pkg::dnsd_rsp_type           rsp
);

   localparam int PosW = $clog2(MSG_BYTES + 1);
   localparam int AW   = $clog2(MSG_BYTES);
   localparam int CmpW = (PosW > 14) ? PosW : 14;
   localparam int NlW  = $clog2(NAME_MAX + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_HEAD, S_TYPE, S_CAP, S_CRD, S_CWR, S_DOT, S_PTR, S_END, S_FLUSH, S_FIN
   } state_type;

   state_type              state_ff, state_in;
   logic [CmpW-1:0]        pos_ff, pos_in;
   logic [CmpW-1:0]        start_ff, start_in;
   logic [4:0]             hops_ff, hops_in;
   logic                   jumped_ff, jumped_in;
   logic [10:0]            used_ff, used_in;
   logic [NlW-1:0]         nlen_ff, nlen_in;
   logic [5:0]             cnt_ff, cnt_in;
   logic [5:0]             lab_ff, lab_in;
   logic [5:0]             hi_ff, hi_in;
   logic [63:0]            buf_ff, buf_in;
   logic [3:0]             bufn_ff, bufn_in;
   logic [2:0]             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   dnsd_pkg::dnsd_rsp_type rsp_ff, rsp_in;

   logic [CmpW-1:0] opa, opb, bound, len_ext, pos_inc;
   logic [CmpW-1:0] used_ptr, used_end;
   logic            over, out_free, emit, push, push_ok;
   logic [7:0]      push_char;
   logic [8:0]      cap_eff;
   dnsd_pkg::dnsd_rsp_type emit_data;

   assign len_ext  = CmpW'(msg_len);
   assign pos_inc  = pos_ff + CmpW'(1);
   assign used_ptr = pos_ff + CmpW'(2) - start_ff;
   assign used_end = pos_ff + CmpW'(1) - start_ff;
   assign cap_eff  = (cap > 9'(NAME_MAX)) ? 9'(NAME_MAX) : cap;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign push_ok  = (bufn_ff != dnsd_pkg::CHUNK_MAX) || out_free;
   assign rd_addr  = (state_ff == S_TYPE) ? pos_inc[AW-1:0] : pos_ff[AW-1:0];
   assign busy     = state_ff != S_IDLE;

   always_comb begin
      opa   = pos_ff;
      opb   = CmpW'(1);
      bound = len_ext;
      unique case (state_ff)
         S_TYPE: begin
            opb = (rd_data[7:6] == dnsd_pkg::TAG_PTR) ? CmpW'(2) : CmpW'(rd_data) + CmpW'(1);
         end
         S_CAP: begin
            opa   = CmpW'(nlen_ff);
            opb   = CmpW'(lab_ff) + CmpW'(2);
            bound = CmpW'(cap_eff);
         end
         S_PTR: begin
            opa = CmpW'({hi_ff, rd_data});
         end
         default: begin
            opa = pos_ff;
         end
      endcase
   end

   dnsd_addcmp #(
      .WIDTH(CmpW)
   ) u_addcmp (
      .opa  (opa),
      .opb  (opb),
      .bound(bound),
      .over (over)
   );

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      hops_in   = hops_ff;
      jumped_in = jumped_ff;
      used_in   = used_ff;
      nlen_in   = nlen_ff;
      cnt_in    = cnt_ff;
      lab_in    = lab_ff;
      hi_in     = hi_ff;
      buf_in    = buf_ff;
      bufn_in   = bufn_ff;
      status_in = status_ff;
      push      = 1'b0;
      push_char = dnsd_pkg::DOT_CHAR;
      emit      = 1'b0;
      emit_data = '{name_chunk: buf_ff, chunk_bytes: bufn_ff, last: 1'b0,
                    status: dnsd_pkg::ST_OK, consumed: 11'd0};

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               pos_in    = CmpW'(start_offset);
               start_in  = CmpW'(start_offset);
               hops_in   = 5'd0;
               jumped_in = 1'b0;
               used_in   = 11'd0;
               nlen_in   = '0;
               buf_in    = 64'd0;
               bufn_in   = 4'd0;
               status_in = dnsd_pkg::ST_OK;
               state_in  = S_HEAD;
            end
         end
         S_HEAD: begin
            if (over) begin
               status_in = dnsd_pkg::ST_BOUNDS;
               state_in  = S_FLUSH;
            end else begin
               state_in = S_TYPE;
            end
         end
         S_TYPE: begin
            if (rd_data[7:6] == dnsd_pkg::TAG_PTR) begin
               if (over) begin
                  status_in = dnsd_pkg::ST_BOUNDS;
                  state_in  = S_FLUSH;
               end else begin
                  if (!jumped_ff) begin
                     jumped_in = 1'b1;
                     used_in   = used_ptr[10:0];
                  end
                  if (hops_ff == dnsd_pkg::MAX_HOPS) begin
                     status_in = dnsd_pkg::ST_LOOP;
                     state_in  = S_FLUSH;
                  end else begin
                     hops_in  = hops_ff + 5'd1;
                     hi_in    = rd_data[5:0];
                     state_in = S_PTR;
                  end
               end
            end else if (rd_data[7:6] != dnsd_pkg::TAG_LABEL) begin
               status_in = dnsd_pkg::ST_RESERVED;
               state_in  = S_FLUSH;
            end else if (rd_data == 8'd0) begin
               if (!jumped_ff) begin
                  used_in = used_end[10:0];
               end
               state_in = S_END;
            end else if (over) begin
               status_in = dnsd_pkg::ST_BOUNDS;
               state_in  = S_FLUSH;
            end else begin
               lab_in   = rd_data[5:0];
               state_in = S_CAP;
            end
         end
         S_CAP: begin
            if (over) begin
               status_in = dnsd_pkg::ST_LONG;
               state_in  = S_FLUSH;
            end else begin
               cnt_in   = lab_ff;
               pos_in   = pos_inc;
               state_in = S_CRD;
            end
         end
         S_CRD: begin
            state_in = S_CWR;
         end
         S_CWR: begin
            push      = 1'b1;
            push_char = rd_data;
            if (push_ok) begin
               pos_in   = pos_inc;
               nlen_in  = nlen_ff + NlW'(1);
               cnt_in   = cnt_ff - 6'd1;
               state_in = (cnt_ff == 6'd1) ? S_DOT : S_CRD;
            end
         end
         S_DOT: begin
            push = 1'b1;
            if (push_ok) begin
               nlen_in  = nlen_ff + NlW'(1);
               state_in = S_HEAD;
            end
         end
         S_PTR: begin
            if (over) begin
               status_in = dnsd_pkg::ST_BOUNDS;
               state_in  = S_FLUSH;
            end else begin
               pos_in   = CmpW'({hi_ff, rd_data});
               state_in = S_HEAD;
            end
         end
         S_END: begin
            if (nlen_ff == '0) begin
               if (cap_eff < 9'd2) begin
                  status_in = dnsd_pkg::ST_LONG;
               end else begin
                  buf_in  = {56'd0, dnsd_pkg::DOT_CHAR};
                  bufn_in = 4'd1;
               end
            end
            state_in = S_FIN;
         end
         S_FLUSH: begin
            if (bufn_ff != dnsd_pkg::CHUNK_MAX) begin
               state_in = S_FIN;
            end else if (out_free) begin
               emit     = 1'b1;
               buf_in   = 64'd0;
               bufn_in  = 4'd0;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = '{name_chunk: buf_ff, chunk_bytes: bufn_ff, last: 1'b1,
                             status: status_ff,
                             consumed: (status_ff == dnsd_pkg::ST_OK) ? used_ff : 11'd0};
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A full chunk leaves when a character must go in, or on a flush.
      if (push && push_ok) begin
         if (bufn_ff == dnsd_pkg::CHUNK_MAX) begin
            emit    = 1'b1;
            buf_in  = {56'd0, push_char};
            bufn_in = 4'd1;
         end else begin
            buf_in[8*bufn_ff[2:0] +: 8] = push_char;
            bufn_in = bufn_ff + 4'd1;
         end
      end

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_in       = emit ? emit_data : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff    <= pos_in;
      start_ff  <= start_in;
      hops_ff   <= hops_in;
      jumped_ff <= jumped_in;
      used_ff   <= used_in;
      nlen_ff   <= nlen_in;
      cnt_ff    <= cnt_in;
      lab_ff    <= lab_in;
      hi_ff     <= hi_in;
      buf_ff    <= buf_in;
      bufn_ff   <= bufn_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== design/dns_name_decompressor_unit.sv =====
// ----------------------------------------------------------------------------
// dns_name_decompressor_unit
// Loads may follow in every cycle while no decode runs. A decode walks labels
// and pointers one store byte at a time, as the single store read port and the
// shared adder demand. Responses wait in an output register.
// Synchronous reset clears length, write position, capacity (256) and the
// sequencer; the message store keeps its contents.
// ----------------------------------------------------------------------------
module dns_name_decompressor_unit #(
   parameter int MSG_BYTES = dnsd_pkg::MSG_BYTES_DEF,
   parameter int NAME_MAX  = dnsd_pkg::NAME_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [7:0]  req_load_byte,
   input  logic        req_load_last,
   input  logic [9:0]  req_start_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_name_chunk,
   output logic [3:0]  rsp_chunk_bytes,
   output logic        rsp_last,
   output logic [2:0]  rsp_status,
   output logic [10:0] rsp_consumed,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:2]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int PosW = $clog2(MSG_BYTES + 1);
   localparam int AW   = $clog2(MSG_BYTES);

   logic [PosW-1:0] wr_pos_ff, wr_pos_in;
   logic [PosW-1:0] msg_len_ff, msg_len_in;
   logic [8:0]      cap_ff, cap_in;
   logic [PosW-1:0] wr_pos_inc;
   logic            req_acc, load_acc, decode_start, wr_en, busy, cap_wr;
   logic [AW-1:0]   rd_addr;
   logic [7:0]      rd_data;
   dnsd_pkg::dnsd_rsp_type rsp;

   assign req_acc      = req_valid && !req_stall;
   assign load_acc     = req_acc && (req_op == dnsd_pkg::OP_LOAD);
   assign decode_start = req_acc && (req_op == dnsd_pkg::OP_DECODE);
   assign req_stall    = busy;
   assign wr_en        = load_acc && (wr_pos_ff != PosW'(MSG_BYTES));
   assign wr_pos_inc   = wr_en ? wr_pos_ff + PosW'(1) : wr_pos_ff;
   assign cap_wr       = psel && penable && pwrite && (paddr[2] == dnsd_pkg::REG_NAME_CAPACITY);

   always_comb begin
      wr_pos_in  = wr_pos_ff;
      msg_len_in = msg_len_ff;
      cap_in     = cap_wr ? pwdata[8:0] : cap_ff;
      if (load_acc) begin
         if (req_load_last) begin
            msg_len_in = wr_pos_inc;
            wr_pos_in  = '0;
         end else begin
            wr_pos_in = wr_pos_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff  <= '0;
         msg_len_ff <= '0;
         cap_ff     <= dnsd_pkg::CAP_RESET;
      end else begin
         wr_pos_ff  <= wr_pos_in;
         msg_len_ff <= msg_len_in;
         cap_ff     <= cap_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == dnsd_pkg::REG_NAME_CAPACITY) ? {23'd0, cap_ff} : 32'd0;

   dnsd_msg_ram #(
      .DEPTH(MSG_BYTES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_pos_ff[AW-1:0]),
      .wr_data(req_load_byte),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   dnsd_walker #(
      .MSG_BYTES(MSG_BYTES),
      .NAME_MAX (NAME_MAX)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .start       (decode_start),
      .start_offset(req_start_offset),
      .msg_len     (msg_len_ff),
      .cap         (cap_ff),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .busy        (busy),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign rsp_name_chunk  = rsp.name_chunk;
   assign rsp_chunk_bytes = rsp.chunk_bytes;
   assign rsp_last        = rsp.last;
   assign rsp_status      = rsp.status;
   assign rsp_consumed    = rsp.consumed;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// DNS name decompressor testbench
// Loads DNS messages into the unit, requests name decodes at chosen offsets
// and checks every response chunk against names rendered by an in-bench
// model of the label and pointer walk. Directed tests cover the root name,
// compression pointers, pointer loops, reserved label types, out-of-bounds
// reads, the name capacity register and a full message store; random
// messages follow, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;

   typedef logic [7:0] msg_bytes_type [$];

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = dnsd_pkg::OP_LOAD;
   logic [7:0]  req_load_byte = 8'h00;
   logic        req_load_last = 1'b0;
   logic [9:0]  req_start_offset = 10'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_name_chunk;
   logic [3:0]  rsp_chunk_bytes;
   logic        rsp_last;
   logic [2:0]  rsp_status;
   logic [10:0] rsp_consumed;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:2]  paddr = dnsd_pkg::REG_NAME_CAPACITY;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   logic [7:0]             msg_store [0:dnsd_pkg::MSG_BYTES_DEF-1];
   int                     msg_length = 0;
   int                     write_pos = 0;
   int                     name_capacity = dnsd_pkg::CAP_RESET;
   dnsd_pkg::dnsd_rsp_type name_chunks_due [$];
   dnsd_pkg::dnsd_rsp_type chunk_due;
   int                     error_count = 0;
   int                     sent_count = 0;
   bit                     idle_off = 1'b0;
   int                     stall_left = 0;
   int                     stall_draw;

   dns_name_decompressor_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_load_byte(req_load_byte),
      .req_load_last(req_load_last),
      .req_start_offset(req_start_offset),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_name_chunk(rsp_name_chunk),
      .rsp_chunk_bytes(rsp_chunk_bytes),
      .rsp_last(rsp_last),
      .rsp_status(rsp_status),
      .rsp_consumed(rsp_consumed),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #20_000_000;
      $display("testbench failed");
      $finish;
   end

   // Renders the name at the given offset and queues the response chunks.
   task automatic decompress_name(input logic [9:0] start);
      logic [7:0]             text [0:dnsd_pkg::NAME_MAX_DEF-1];
      logic [7:0]             lead;
      logic [2:0]             status;
      int                     cap, pos, hops, nlen, used, full, count, target;
      bit                     jumped, done;
      dnsd_pkg::dnsd_rsp_type chunk;
      cap = (name_capacity > dnsd_pkg::NAME_MAX_DEF) ? dnsd_pkg::NAME_MAX_DEF : name_capacity;
      pos = start;
      hops = 0;
      nlen = 0;
      used = 0;
      jumped = 1'b0;
      done = 1'b0;
      status = dnsd_pkg::ST_OK;
      while (!done) begin
         done = 1'b1;
         if (pos >= msg_length) begin
            status = dnsd_pkg::ST_BOUNDS;
         end else if (msg_store[pos][7:6] == dnsd_pkg::TAG_PTR) begin
            if (msg_length - pos < 2) begin
               status = dnsd_pkg::ST_BOUNDS;
            end else begin
               if (!jumped) begin
                  used = pos + 2 - start;
                  jumped = 1'b1;
               end
               hops++;
               target = {msg_store[pos][5:0], msg_store[pos + 1]};
               if (hops > dnsd_pkg::MAX_HOPS) begin
                  status = dnsd_pkg::ST_LOOP;
               end else if (target >= msg_length) begin
                  status = dnsd_pkg::ST_BOUNDS;
               end else begin
                  pos = target;
                  done = 1'b0;
               end
            end
         end else if (msg_store[pos][7:6] != dnsd_pkg::TAG_LABEL) begin
            status = dnsd_pkg::ST_RESERVED;
         end else if (msg_store[pos] == 8'h00) begin
            pos++;
         end else begin
            lead = msg_store[pos];
            if (msg_length - pos < lead + 1) begin
               status = dnsd_pkg::ST_BOUNDS;
            end else if (nlen + lead + 2 > cap) begin
               status = dnsd_pkg::ST_LONG;
            end else begin
               for (int i = 0; i < lead; i++)
                  text[nlen + i] = msg_store[pos + 1 + i];
               nlen += lead;
               text[nlen] = dnsd_pkg::DOT_CHAR;
               nlen++;
               pos += lead + 1;
               done = 1'b0;
            end
         end
      end
      if (status == dnsd_pkg::ST_OK) begin
         if (nlen == 0) begin
            if (cap < 2) begin
               status = dnsd_pkg::ST_LONG;
            end else begin
               text[0] = dnsd_pkg::DOT_CHAR;
               nlen = 1;
            end
         end
         if (!jumped)
            used = pos - start;
      end
      if (status != dnsd_pkg::ST_OK)
         used = 0;
      full = (status == dnsd_pkg::ST_OK) ? (nlen - 1) / 8 : nlen / 8;
      for (int k = 0; k <= full; k++) begin
         chunk = '0;
         count = (k < full) ? 8 : nlen - full * 8;
         for (int i = 0; i < count; i++)
            chunk.name_chunk[8 * i +: 8] = text[8 * k + i];
         chunk.chunk_bytes = count[3:0];
         chunk.last = (k == full);
         chunk.status = (k == full) ? status : dnsd_pkg::ST_OK;
         chunk.consumed = (k == full) ? used[10:0] : 11'd0;
         name_chunks_due.push_back(chunk);
      end
   endtask

   task automatic drive_request(input logic op, input logic [7:0] data, input logic fin,
                                input logic [9:0] offset);
      int gap;
      gap = idle_off ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_load_byte <= data;
      req_load_last <= fin;
      req_start_offset <= offset;
      do @(posedge clock); while (req_stall);
      sent_count++;
      if (op == dnsd_pkg::OP_LOAD) begin
         if (write_pos < dnsd_pkg::MSG_BYTES_DEF) begin
            msg_store[write_pos] = data;
            write_pos++;
         end
         if (fin) begin
            msg_length = write_pos;
            write_pos = 0;
         end
      end else begin
         decompress_name(offset);
      end
   endtask

   task automatic decode_at(input int offset);
      drive_request(dnsd_pkg::OP_DECODE, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), offset[9:0]);
   endtask

   // A decode of the stored message is slipped in before byte mid, if mid is in range.
   task automatic load_message(ref msg_bytes_type msg, input int mid);
      foreach (msg[i]) begin
         if (i == mid)
            decode_at($urandom_range(0, msg_length));
         drive_request(dnsd_pkg::OP_LOAD, msg[i], i == msg.size() - 1,
                       10'($urandom_range(0, 1023)));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (name_chunks_due.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic set_name_capacity(input logic [8:0] value);
      wait_idle();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= dnsd_pkg::REG_NAME_CAPACITY;
      pwdata <= {23'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      name_capacity = value;
   endtask

   task automatic add_label(ref msg_bytes_type msg, input string s);
      msg.push_back(8'(s.len()));
      for (int i = 0; i < s.len(); i++)
         msg.push_back(s[i]);
   endtask

   task automatic add_random_label(ref msg_bytes_type msg, input int len);
      msg.push_back(8'(len));
      repeat (len) msg.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_pointer(ref msg_bytes_type msg, input int target);
      logic [13:0] t;
      t = target[13:0];
      msg.push_back({dnsd_pkg::TAG_PTR, t[13:8]});
      msg.push_back(t[7:0]);
   endtask

   task automatic append_random_names(ref msg_bytes_type msg, ref int starts [$],
                                      input int names);
      int kind;
      repeat (names) begin
         starts.push_back(msg.size());
         repeat ($urandom_range(0, 3))
            add_random_label(msg, ($urandom_range(0, 9) == 0) ?
                             $urandom_range(7, 63) : $urandom_range(1, 6));
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            msg.push_back(8'h00);
         end else if (kind < 8) begin
            add_pointer(msg, starts[$urandom_range(0, starts.size() - 1)]);
         end else if (kind == 8) begin
            add_pointer(msg, $urandom_range(0, 16383));
         end else begin
            msg.push_back(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic test_empty_message();
      decode_at(0);
      decode_at(1023);
      decode_at($urandom_range(0, 1023));
   endtask

   task automatic test_directed_names();
      msg_bytes_type msg;
      int            offsets [] = '{0, 1, 5, 13, 18, 25, 27, 28, 29, 31, 33, 36, 37, 1023};
      msg.push_back(8'h00);
      add_label(msg, "www");
      add_label(msg, "example");
      add_label(msg, "com");
      msg.push_back(8'h00);
      add_label(msg, "mail");
      add_pointer(msg, 5);
      add_pointer(msg, 18);
      msg.push_back(8'h40);
      msg.push_back(8'h80);
      add_pointer(msg, 29);
      add_pointer(msg, 16'h3fff);
      msg.push_back(8'h05);
      msg.push_back("a");
      msg.push_back("b");
      msg.push_back(8'hc0);
      load_message(msg, -1);
      foreach (offsets[i])
         decode_at(offsets[i]);
   endtask

   // Sixteen pointers in a row still resolve; the seventeenth is a loop.
   task automatic test_pointer_chains();
      msg_bytes_type msg;
      msg.push_back(8'h00);
      for (int k = 0; k <= 16; k++)
         add_pointer(msg, (k == 0) ? 0 : 1 + 2 * (k - 1));
      add_label(msg, "x");
      add_pointer(msg, 31);
      load_message(msg, 20);
      decode_at(31);
      decode_at(33);
      decode_at(1);
      decode_at(35);
   endtask

   task automatic test_name_capacity();
      msg_bytes_type msg;
      int            caps [] = '{14, 255, 3, 2, 1, 0, 300, 511, 256};
      add_random_label(msg, 63);
      add_random_label(msg, 63);
      add_random_label(msg, 63);
      add_random_label(msg, 62);
      msg.push_back(8'h00);
      add_label(msg, "a");
      msg.push_back(8'h00);
      msg.push_back(8'h00);
      add_random_label(msg, 10);
      add_random_label(msg, 3);
      msg.push_back(8'h00);
      load_message(msg, -1);
      foreach (caps[i]) begin
         set_name_capacity(9'(caps[i]));
         decode_at(0);
         decode_at(256);
         decode_at(259);
         decode_at(260);
      end
   endtask

   // Bytes beyond the store are dropped and the length stops at the store size.
   task automatic test_full_store();
      msg_bytes_type msg;
      int            starts [$];
      idle_off = 1'b1;
      while (msg.size() < dnsd_pkg::MSG_BYTES_DEF - 1)
         append_random_names(msg, starts, 4);
      msg = msg[0:dnsd_pkg::MSG_BYTES_DEF-2];
      msg.push_back(8'h00);
      repeat (6) msg.push_back(8'($urandom_range(0, 255)));
      load_message(msg, -1);
      idle_off = 1'b0;
      decode_at(dnsd_pkg::MSG_BYTES_DEF - 1);
      repeat (8) decode_at(starts[$urandom_range(0, starts.size() - 1)]);
   endtask

   task automatic test_random_messages();
      msg_bytes_type msg;
      int            starts [$];
      int            first, pick, cap;
      first = sent_count;
      while (sent_count - first < 230) begin
         if ($urandom_range(0, 2) == 0) begin
            pick = $urandom_range(0, 5);
            if (pick == 0)
               cap = $urandom_range(0, 1);
            else if (pick == 1)
               cap = $urandom_range(257, 511);
            else
               cap = $urandom_range(2, 256);
            set_name_capacity(9'(cap));
         end
         idle_off = ($urandom_range(0, 4) == 0);
         msg.delete();
         starts.delete();
         append_random_names(msg, starts, $urandom_range(2, 5));
         load_message(msg, ($urandom_range(0, 3) == 0) ? $urandom_range(0, msg.size() - 1) : -1);
         repeat ($urandom_range(6, 14)) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               decode_at(starts[$urandom_range(0, starts.size() - 1)]);
            else if (pick < 9)
               decode_at($urandom_range(0, msg.size() - 1));
            else
               decode_at($urandom_range(0, 1023));
         end
      end
      idle_off = 1'b0;
   endtask

   function automatic void check_field(input string field, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         if (name_chunks_due.size() == 0) begin
            $error("response received with no name chunk pending");
            error_count++;
         end else begin
            chunk_due = name_chunks_due.pop_front();
            check_field("name_chunk", chunk_due.name_chunk, rsp_name_chunk);
            check_field("chunk_bytes", chunk_due.chunk_bytes, rsp_chunk_bytes);
            check_field("last", chunk_due.last, rsp_last);
            check_field("status", chunk_due.status, rsp_status);
            check_field("consumed", chunk_due.consumed, rsp_consumed);
         end
         stall_draw = idle_off ? 0 : $urandom_range(0, 15);
         rsp_stall <= (stall_draw != 0);
         stall_left <= stall_draw;
      end else if (rsp_stall) begin
         if (stall_left <= 1)
            rsp_stall <= 1'b0;
         stall_left <= stall_left - 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_message();
      test_directed_names();
      test_pointer_chains();
      test_name_capacity();
      test_full_store();
      test_random_messages();
      wait_idle();
      if (error_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

// ===== dns_name_decompressor_unit.f =====
design/dnsd_pkg.sv
design/dnsd_msg_ram.sv
design/dnsd_addcmp.sv
design/dnsd_walker.sv
design/dns_name_decompressor_unit.sv
test/testbench.sv
